// ----- rtl/wrcd_pkg.sv -----
// Shared types, widths and helpers of the windowed residual collision detector.
// Used by wrcd_window and windowed_residual_collision_detector; no dependencies.
package wrcd_pkg;

  localparam int JOINT_W     = 3;   // joint_index field
  localparam int RES_W       = 32;  // residual, signed Q15.16
  localparam int MAG_W       = 32;  // unsigned magnitude, holds 2^31
  localparam int TIME_W      = 32;  // step time and arming time register
  localparam int EPS_W       = 31;  // epsilon_margin
  localparam int JNUM_W      = 4;   // joint number 1..8, 0 for none
  localparam int IN_TDATA_W  = 72;  // 67 payload bits padded to bytes
  localparam int OUT_TDATA_W = 8;   // 5 payload bits padded to bytes
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 32;

  localparam int DEF_MAX_JOINTS   = 8;
  localparam int DEF_WINDOW_DEPTH = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_EPSILON_MARGIN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_TIME     = 1'd1;

  // Command from the sequencer to the window unit.
  typedef struct packed {
    logic               start;     // push and scan one row
    logic [JOINT_W-1:0] joint;
    logic [MAG_W-1:0]   push_mag;  // magnitude of the previous sample
  } scan_cmd_t;

  // Result of one window scan.
  typedef struct packed {
    logic             done;
    logic [MAG_W-1:0] wmax;
    logic [MAG_W-1:0] wmin;
  } scan_sts_t;

  // Two's complement magnitude; the most negative value maps to 2^31.
  function automatic logic [MAG_W-1:0] magnitude_of(input logic [RES_W-1:0] raw);
    logic [MAG_W-1:0] mag;
    mag = raw[RES_W-1] ? (~raw) + 1'b1 : raw;
    return mag;
  endfunction

endpackage

// ----- rtl/wrcd_window.sv -----
// Per-joint window of past magnitudes held in one synchronous memory.
// Pushes one magnitude into a row, then scans the row for maximum and minimum.
// Depends on wrcd_pkg.
module wrcd_window import wrcd_pkg::*; #(
  parameter int MAX_JOINTS   = DEF_MAX_JOINTS,
  parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  scan_cmd_t cmd_i,
  output scan_sts_t sts_o
);

  localparam int ROW_W     = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
  localparam int PTR_W     = $clog2(WINDOW_DEPTH);
  localparam int CNT_W     = $clog2(WINDOW_DEPTH + 1);
  localparam int ADDR_W    = ROW_W + PTR_W;
  localparam int MEM_DEPTH = MAX_JOINTS * (2 ** PTR_W);
  localparam logic [PTR_W-1:0] LAST_K = PTR_W'(WINDOW_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL   = CNT_W'(WINDOW_DEPTH);

  logic [MAG_W-1:0] win_mem [MEM_DEPTH];

  logic [PTR_W-1:0] ptr_r  [MAX_JOINTS];  // next slot to write, per row
  logic [CNT_W-1:0] fill_r [MAX_JOINTS];  // slots written so far, saturating
  logic [ROW_W-1:0] row_r;
  logic [CNT_W-1:0] fill_cur_r;
  logic [PTR_W-1:0] k_r;
  logic             issue_r;
  logic             rd_pend_r;
  logic             rd_last_r;
  logic             rd_inwin_r;
  logic [MAG_W-1:0] rd_data_r;
  logic [MAG_W-1:0] max_r;
  logic [MAG_W-1:0] min_r;
  logic             done_r;

  logic [ROW_W-1:0] row;
  logic [CNT_W-1:0] fill_nxt;
  logic [MAG_W-1:0] val;

  assign row      = ROW_W'(cmd_i.joint);
  assign fill_nxt = (fill_r[row] == FULL) ? FULL : fill_r[row] + 1'b1;
  // Slots never written read as zero.
  assign val      = rd_inwin_r ? rd_data_r : '0;

  // Window memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd_i.start) begin
      win_mem[ADDR_W'({row, ptr_r[row]})] <= cmd_i.push_mag;
    end
    rd_data_r <= win_mem[ADDR_W'({row_r, k_r})];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < MAX_JOINTS; j++) begin
        ptr_r[j]  <= '0;
        fill_r[j] <= '0;
      end
      issue_r   <= 1'b0;
      rd_pend_r <= 1'b0;
      done_r    <= 1'b0;
    end else begin
      if (cmd_i.start) begin
        ptr_r[row]  <= (ptr_r[row] == LAST_K) ? '0 : ptr_r[row] + 1'b1;
        fill_r[row] <= fill_nxt;
        issue_r     <= 1'b1;
      end else if (issue_r && k_r == LAST_K) begin
        issue_r <= 1'b0;
      end
      rd_pend_r <= issue_r;
      done_r    <= rd_pend_r && rd_last_r;
    end
  end

  // Scan address, read tags and the running extremes.
  always_ff @(posedge clk) begin
    if (cmd_i.start) begin
      row_r      <= row;
      fill_cur_r <= fill_nxt;
      k_r        <= '0;
      max_r      <= '0;
      min_r      <= '1;
    end else begin
      if (issue_r) begin
        k_r <= k_r + 1'b1;
      end
      if (rd_pend_r) begin
        if (val > max_r) max_r <= val;
        if (val < min_r) min_r <= val;
      end
    end
    rd_inwin_r <= CNT_W'(k_r) < fill_cur_r;
    rd_last_r  <= k_r == LAST_K;
  end

  assign sts_o.done = done_r;
  assign sts_o.wmax = max_r;
  assign sts_o.wmin = min_r;

endmodule

// ----- rtl/windowed_residual_collision_detector.sv -----
// Top level of the windowed residual collision detector.
// Instantiates wrcd_window; depends on wrcd_pkg.
//
// One item is one joint residual of a control step, joints in ascending order,
// the last joint marked by in_tlast. For each joint in range the block reads
// the stored previous sample, pushes its magnitude into that joint's window
// of WINDOW_DEPTH past magnitudes, scans the window for maximum and minimum,
// and stores the new sample. A current magnitude above max + epsilon_margin
// marks the joint as exceeding; the latched joint falling below
// min - epsilon_margin marks a release. On the last joint, once step_time is
// beyond the arming time register, an idle detector latches the highest
// exceeding joint and an active one clears on a release; then one result
// (collision_active, collision_joint) goes out. Items that are not last give
// no result. A joint index at or above MAX_JOINTS changes nothing but still
// ends the step if marked last. The window scan of an in-range item reads
// one entry per cycle through the single read port of the window memory, and
// no new item is taken until the current one is through; a last item then
// loads the result once the output register is free. A result waits in the
// output register while the next item is taken.
// No clearing pass follows reset: a per-joint fill count makes unwritten
// window slots read as zero, and valid bits do the same for the
// previous-sample memory. Configuration writes via cfg_we/cfg_index/cfg_wdata
// are taken in any cycle and belong in idle time.
module windowed_residual_collision_detector import wrcd_pkg::*; #(
  parameter int MAX_JOINTS   = DEF_MAX_JOINTS,
  parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // joint_index[2:0], residual[34:3], step_time[66:35], zero pad [71:67]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   in_tlast,   // last_joint
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // collision_active[0], collision_joint[4:1], zero pad [7:5]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int ROW_W = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
  localparam logic [JOINT_W+1:0] NJ = (JOINT_W + 2)'(MAX_JOINTS);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_PREV   = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  // Unpacked input fields.
  logic [JOINT_W-1:0] in_joint;
  logic [RES_W-1:0]   in_residual;
  logic [TIME_W-1:0]  in_time;
  logic               in_acc;
  logic               in_range;
  logic [ROW_W-1:0]   in_row;

  assign in_joint    = in_tdata[JOINT_W-1:0];
  assign in_residual = in_tdata[JOINT_W+RES_W-1:JOINT_W];
  assign in_time     = in_tdata[JOINT_W+RES_W+TIME_W-1:JOINT_W+RES_W];
  assign in_tready   = (state_r == ST_IDLE);
  assign in_acc      = in_tvalid && in_tready;
  assign in_range    = {2'b00, in_joint} < NJ;
  assign in_row      = ROW_W'(in_joint);

  // Held item.
  logic [JOINT_W-1:0] joint_r;
  logic [RES_W-1:0]   raw_r;
  logic [MAG_W-1:0]   cur_mag_r;
  logic [TIME_W-1:0]  step_r;
  logic               last_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      joint_r   <= in_joint;
      raw_r     <= in_residual;
      cur_mag_r <= magnitude_of(in_residual);
      step_r    <= in_time;
      last_r    <= in_tlast;
    end
  end

  // Configuration registers.
  logic [EPS_W-1:0]  eps_r;
  logic [TIME_W-1:0] start_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r   <= '0;
      start_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_EPSILON_MARGIN: eps_r   <= cfg_wdata[EPS_W-1:0];
        CFG_START_TIME:     start_r <= cfg_wdata[TIME_W-1:0];
        default:            ;
      endcase
    end
  end

  // Previous-sample memory, read on accept, written back in the push cycle.
  logic [RES_W-1:0]      prev_mem [MAX_JOINTS];
  logic [RES_W-1:0]      prev_rd_r;
  logic [MAX_JOINTS-1:0] prev_vld_r;
  logic                  prev_hit_r;
  logic [ROW_W-1:0]      row_j;

  assign row_j = ROW_W'(joint_r);

  always_ff @(posedge clk) begin
    if (state_r == ST_PREV) begin
      prev_mem[row_j] <= raw_r;
    end
    prev_rd_r  <= prev_mem[in_row];
    prev_hit_r <= prev_vld_r[in_row];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_vld_r <= '0;
    end else if (state_r == ST_PREV) begin
      prev_vld_r[row_j] <= 1'b1;
    end
  end

  // Window unit.
  scan_cmd_t scan_cmd;
  scan_sts_t scan_sts;

  assign scan_cmd.start    = (state_r == ST_PREV);
  assign scan_cmd.joint    = joint_r;
  assign scan_cmd.push_mag = prev_hit_r ? magnitude_of(prev_rd_r) : '0;

  wrcd_window #(
    .MAX_JOINTS  (MAX_JOINTS),
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) u_window (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd_i(scan_cmd),
    .sts_o(scan_sts)
  );

  // Per-step flags and the latched collision.
  logic              active_r, active_nxt;
  logic [JNUM_W-1:0] act_joint_r, act_joint_nxt;
  logic [JNUM_W-1:0] highest_r, highest_nxt;
  logic              release_r, release_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [JNUM_W:0]   out_data_r, out_data_nxt;

  logic [JNUM_W-1:0] jnum;
  logic [MAG_W:0]    max_lim;
  logic [MAG_W:0]    cur_lo;
  logic              exceed;
  logic              falls;
  logic              out_free;

  assign jnum     = JNUM_W'(joint_r) + 1'b1;
  // Exact 33-bit compares: nothing wraps.
  assign max_lim  = {1'b0, scan_sts.wmax} + (MAG_W + 1)'(eps_r);
  assign cur_lo   = {1'b0, cur_mag_r} + (MAG_W + 1)'(eps_r);
  assign exceed   = {1'b0, cur_mag_r} > max_lim;
  assign falls    = cur_lo < {1'b0, scan_sts.wmin};
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    active_nxt    = active_r;
    act_joint_nxt = act_joint_r;
    highest_nxt   = highest_r;
    release_nxt   = release_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_tready ? 1'b0 : out_valid_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_range) state_nxt = ST_PREV;
          else if (in_tlast) state_nxt = ST_FINISH;
        end
      end
      ST_PREV: begin
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (scan_sts.done) begin
          if (exceed && jnum > highest_r) highest_nxt = jnum;
          if (active_r && act_joint_r == jnum && falls) release_nxt = 1'b1;
          state_nxt = last_r ? ST_FINISH : ST_IDLE;
        end
      end
      ST_FINISH: begin
        // Hold until the output register is free, then decide and emit.
        if (out_free) begin
          if (step_r > start_r) begin
            if (!active_r) begin
              if (highest_r != '0) begin
                active_nxt    = 1'b1;
                act_joint_nxt = highest_r;
              end
            end else if (release_r) begin
              active_nxt    = 1'b0;
              act_joint_nxt = '0;
            end
          end
          highest_nxt   = '0;
          release_nxt   = 1'b0;
          out_data_nxt  = {act_joint_nxt, active_nxt};
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      active_r    <= 1'b0;
      act_joint_r <= '0;
      highest_r   <= '0;
      release_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      act_joint_r <= act_joint_nxt;
      highest_r   <= highest_nxt;
      release_r   <= release_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_data_r);

endmodule
